### sv/tted_pkg.sv
// Shared types, codes and helpers for the text terminal escape decoder.
`timescale 1ns / 1ps

package tted_pkg;

    // Default limits of the block.
    localparam int MAX_ROWS_DEF    = 256;
    localparam int MAX_COLS_DEF    = 256;
    localparam int COLOR_COUNT_DEF = 16;

    // Reset values of the configuration registers.
    localparam logic [3:0] NORMAL_FG_RST   = 4'd0;
    localparam logic [3:0] NORMAL_BG_RST   = 4'd15;
    localparam logic [8:0] SCREEN_ROWS_RST = 9'd24;
    localparam logic [8:0] SCREEN_COLS_RST = 9'd80;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    // Byte codes the parser recognizes.
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_M   = 8'h6D;

    // Text mode bits.
    localparam int MODE_REVERSE_BIT = 0;
    localparam int MODE_BOLD_BIT    = 1;

    typedef enum logic [2:0] {
        PH_GROUND = 3'd0,
        PH_ESC    = 3'd1,
        PH_CSI    = 3'd2,
        PH_NUM1   = 3'd3,
        PH_NUM2   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CMD_GLYPH  = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_EOL    = 3'd2,
        CMD_SCROLL = 3'd3,
        CMD_INSERT = 3'd4,
        CMD_ERROR  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_NORMAL_FG   = 2'd0,
        CFG_NORMAL_BG   = 2'd1,
        CFG_SCREEN_ROWS = 2'd2,
        CFG_SCREEN_COLS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] cell_row;
        logic [7:0] cell_col;
        logic [7:0] glyph;
        logic [3:0] fore_index;
        logic [3:0] back_index;
        logic       bold_on;
        logic [7:0] region_top;
        logic [8:0] region_bottom;
        logic [7:0] region_left;
        logic [8:0] region_right;
        logic       final_result;
    } result_t;

    // Fill in the per-command part of a result that already carries the attributes.
    function automatic result_t make_result(input result_t base, input cmd_t cmd,
                                            input logic [7:0] row, input logic [7:0] col,
                                            input logic [7:0] gl);
        result_t r;
        r          = base;
        r.command  = cmd;
        r.cell_row = row;
        r.cell_col = col;
        r.glyph    = gl;
        return r;
    endfunction

    // Decimal accumulate with saturation at 255.
    function automatic logic [7:0] acc_sat(input logic [7:0] v, input logic [3:0] d);
        logic [11:0] w;
        w = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {8'b0, d};
        return (w > 12'd255) ? 8'hFF : w[7:0];
    endfunction

    // Clamp a size register to 1..limit.
    function automatic logic [8:0] clamp_size(input logic [8:0] v, input logic [8:0] lim);
        logic [8:0] r;
        r = v;
        if (r == 9'd0) begin
            r = 9'd1;
        end
        if (r > lim) begin
            r = lim;
        end
        return r;
    endfunction

endpackage

### sv/text_terminal_escape_decoder.sv
// Top level of the text terminal escape decoder: parser, cursor state and result queue.
`timescale 1ns / 1ps

// Character-cell terminal front end. Bytes written to the terminal enter on the
// s_ channel (valid/ready), one byte per beat, with s_end_of_write marking the
// last byte of a write. Draw commands leave on the m_ channel (valid/ready),
// one command per beat, each carrying the cursor cell, the glyph byte, the
// current colors, bold and the scroll region; m_final_result marks the last
// command a byte produced. A byte yields zero, one or two commands.
// Configuration registers (default colors, screen size) are written through
// cfg_wr_en/cfg_index/cfg_wdata; the user must write them only while the block
// is idle, which the block itself does not enforce. A byte is decoded and the
// state updated in the cycle it is accepted; its commands go into a four-entry
// queue and, when the queue was empty, show on m_ from the next cycle. One byte
// is accepted per cycle as long as the queue has room for two commands; a byte
// that makes two commands takes one output beat for each, and the output
// port's one beat per cycle is the limit. When the receiver stalls the queue
// fills and s_ready drops once fewer than two entries are free. Reset is
// synchronous: the parser returns to ground, cursor and region go home, colors
// take the register defaults and the queue empties.
module text_terminal_escape_decoder #(
    parameter int MAX_ROWS    = tted_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = tted_pkg::MAX_COLS_DEF,
    parameter int COLOR_COUNT = tted_pkg::COLOR_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_wdata,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_write,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_command,
    output logic [7:0] m_cell_row,
    output logic [7:0] m_cell_col,
    output logic [7:0] m_glyph,
    output logic [3:0] m_fore_index,
    output logic [3:0] m_back_index,
    output logic       m_bold_on,
    output logic [7:0] m_region_top,
    output logic [8:0] m_region_bottom,
    output logic [7:0] m_region_left,
    output logic [8:0] m_region_right,
    output logic       m_final_result
);
    import tted_pkg::*;

    localparam logic [8:0] ROWS_LIM  = 9'(MAX_ROWS);
    localparam logic [8:0] COLS_LIM  = 9'(MAX_COLS);
    localparam logic [4:0] NCOLORS   = 5'(COLOR_COUNT);
    localparam logic [8:0] ROWS_RST  = (SCREEN_ROWS_RST > 9'(MAX_ROWS)) ?
                                       9'(MAX_ROWS) : SCREEN_ROWS_RST;
    localparam logic [8:0] COLS_RST  = (SCREEN_COLS_RST > 9'(MAX_COLS)) ?
                                       9'(MAX_COLS) : SCREEN_COLS_RST;

    // Configuration registers.
    logic [3:0] normal_fg_reg, normal_bg_reg;
    logic [8:0] screen_rows_reg, screen_cols_reg;

    // Terminal state.
    phase_t     phase_reg, phase_next;
    logic [7:0] n1_reg, n1_next, n2_reg, n2_next;
    logic [7:0] row_reg, row_next, col_reg, col_next;
    logic [7:0] top_reg, top_next, left_reg, left_next;
    logic [8:0] bottom_reg, bottom_next, right_reg, right_next;
    logic [3:0] fg_reg, fg_next, bg_reg, bg_next;
    logic [1:0] mode_reg, mode_next;

    // Result queue.
    result_t          queue_mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    // Decode outputs.
    result_t    base, res0, res1;
    logic [1:0] res_cnt;
    logic       accept, pop;
    logic       is_digit, do_ground;
    logic [3:0] digit_val;
    logic [8:0] rows_eff, cols_eff, lim, span_end, span_m1, col_p1, row_p1;
    logic [3:0] fg_t, bg_t;
    result_t    head;

    assign accept = s_valid && s_ready;
    assign pop    = m_valid && m_ready;
    assign s_ready = (count_reg <= QCW'(QDEPTH - 2));
    assign m_valid = (count_reg != '0);

    assign rows_eff = clamp_size(screen_rows_reg, ROWS_LIM);
    assign cols_eff = clamp_size(screen_cols_reg, COLS_LIM);

    always_comb begin
        base               = '0;
        base.fore_index    = fg_reg;
        base.back_index    = bg_reg;
        base.bold_on       = mode_reg[MODE_BOLD_BIT];
        base.region_top    = top_reg;
        base.region_bottom = bottom_reg;
        base.region_left   = left_reg;
        base.region_right  = right_reg;

        phase_next  = phase_reg;
        n1_next     = n1_reg;
        n2_next     = n2_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        mode_next   = mode_reg;
        res0        = base;
        res1        = base;
        res_cnt     = 2'd0;
        do_ground   = 1'b0;
        lim         = '0;
        span_end    = '0;
        span_m1     = '0;
        fg_t        = fg_reg;
        bg_t        = bg_reg;

        is_digit  = (s_data_byte >= CH_0) && (s_data_byte <= CH_9);
        digit_val = s_data_byte[3:0];
        col_p1    = {1'b0, col_reg} + 9'd1;
        row_p1    = {1'b0, row_reg} + 9'd1;

        case (phase_reg)
            PH_ESC: begin
                if (s_data_byte == CH_LBRACK) begin
                    phase_next = s_end_of_write ? PH_GROUND : PH_CSI;
                end else begin
                    do_ground = 1'b1;
                end
            end
            PH_CSI: begin
                phase_next = PH_GROUND;
                if (s_data_byte == CH_J) begin
                    row_next = '0;
                    col_next = '0;
                    res0     = make_result(base, CMD_CLEAR, 8'd0, 8'd0, 8'd0);
                    res_cnt  = 2'd1;
                end else if (s_data_byte == CH_K) begin
                    res0    = make_result(base, CMD_EOL, row_reg, col_reg, 8'd0);
                    res_cnt = 2'd1;
                end else if (s_data_byte == CH_L) begin
                    res0    = make_result(base, CMD_INSERT, row_reg, col_reg, 8'd0);
                    res_cnt = 2'd1;
                end else if (is_digit && !s_end_of_write) begin
                    n1_next    = {4'b0, digit_val};
                    n2_next    = '0;
                    phase_next = PH_NUM1;
                end else begin
                    res0    = make_result(base, CMD_ERROR, row_reg, col_reg, 8'd0);
                    res_cnt = 2'd1;
                end
            end
            PH_NUM1, PH_NUM2: begin
                if (is_digit || (s_data_byte == CH_SEMI && phase_reg == PH_NUM1)) begin
                    if (s_end_of_write) begin
                        phase_next = PH_GROUND;
                        res0       = make_result(base, CMD_ERROR, row_reg, col_reg, 8'd0);
                        res_cnt    = 2'd1;
                    end else if (s_data_byte == CH_SEMI) begin
                        phase_next = PH_NUM2;
                        n2_next    = '0;
                    end else if (phase_reg == PH_NUM1) begin
                        n1_next = acc_sat(n1_reg, digit_val);
                    end else begin
                        n2_next = acc_sat(n2_reg, digit_val);
                    end
                end else begin
                    // The final byte of a numbered sequence.
                    phase_next = PH_GROUND;
                    case (s_data_byte)
                        CH_LC_B: begin
                            if ({1'b0, n1_reg} < {4'b0, NCOLORS}) begin
                                bg_next = n1_reg[3:0];
                            end
                        end
                        CH_LC_F: begin
                            if ({1'b0, n1_reg} < {4'b0, NCOLORS}) begin
                                fg_next = n1_reg[3:0];
                            end
                        end
                        CH_H: begin
                            lim      = rows_eff - 9'd1;
                            row_next = ({1'b0, n1_reg} > lim) ? lim[7:0] : n1_reg;
                            lim      = cols_eff - 9'd1;
                            col_next = ({1'b0, n2_reg} > lim) ? lim[7:0] : n2_reg;
                        end
                        CH_LC_M: begin
                            // A change of the reverse bit swaps the colors first.
                            if (mode_reg[MODE_REVERSE_BIT] != n1_reg[MODE_REVERSE_BIT]) begin
                                fg_t = bg_reg;
                                bg_t = fg_reg;
                            end
                            if (n1_reg == 8'd0) begin
                                if ({1'b0, normal_bg_reg} < NCOLORS) begin
                                    bg_t = normal_bg_reg;
                                end
                                if ({1'b0, normal_fg_reg} < NCOLORS) begin
                                    fg_t = normal_fg_reg;
                                end
                            end
                            fg_next   = fg_t;
                            bg_next   = bg_t;
                            mode_next = n1_reg[1:0];
                        end
                        CH_R: begin
                            span_end    = {1'b0, n2_reg} + 9'd1;
                            span_end    = (span_end > rows_eff) ? rows_eff : span_end;
                            span_m1     = span_end - 9'd1;
                            bottom_next = span_end;
                            top_next    = ({1'b0, n1_reg} > span_m1) ? span_m1[7:0] : n1_reg;
                        end
                        CH_V: begin
                            span_end   = {1'b0, n2_reg} + 9'd1;
                            span_end   = (span_end > cols_eff) ? cols_eff : span_end;
                            span_m1    = span_end - 9'd1;
                            right_next = span_end;
                            left_next  = ({1'b0, n1_reg} > span_m1) ? span_m1[7:0] : n1_reg;
                        end
                        default: begin
                            res0    = make_result(base, CMD_ERROR, row_reg, col_reg, 8'd0);
                            res_cnt = 2'd1;
                        end
                    endcase
                end
            end
            default: begin
                do_ground = 1'b1;
            end
        endcase

        if (do_ground) begin
            phase_next = PH_GROUND;
            case (s_data_byte)
                CH_BEL: begin
                end
                CH_BS: begin
                    if (col_reg > left_reg) begin
                        col_next = col_reg - 8'd1;
                    end else if (row_reg > top_reg) begin
                        span_m1  = right_reg - 9'd1;
                        row_next = row_reg - 8'd1;
                        col_next = span_m1[7:0];
                    end
                end
                CH_LF: begin
                    col_next = left_reg;
                    if (row_p1 >= bottom_reg) begin
                        span_m1  = bottom_reg - 9'd1;
                        row_next = span_m1[7:0];
                        res0     = make_result(base, CMD_SCROLL, span_m1[7:0], left_reg, 8'd0);
                        res_cnt  = 2'd1;
                    end else begin
                        row_next = row_p1[7:0];
                    end
                end
                CH_CR: begin
                    col_next = left_reg;
                end
                CH_ESC: begin
                    phase_next = s_end_of_write ? PH_GROUND : PH_ESC;
                end
                default: begin
                    // Bytes at or right of the region's right edge are dropped.
                    if ({1'b0, col_reg} < right_reg) begin
                        res0    = make_result(base, CMD_GLYPH, row_reg, col_reg, s_data_byte);
                        res_cnt = 2'd1;
                        if (col_p1 >= right_reg) begin
                            col_next = left_reg;
                            if (row_p1 == bottom_reg) begin
                                res1    = make_result(base, CMD_SCROLL, row_reg, left_reg, 8'd0);
                                res_cnt = 2'd2;
                            end else if (row_reg != 8'hFF) begin
                                row_next = row_p1[7:0];
                            end
                        end else begin
                            col_next = col_p1[7:0];
                        end
                    end
                end
            endcase
        end

        res0.final_result = (res_cnt == 2'd1);
        res1.final_result = 1'b1;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_fg_reg   <= NORMAL_FG_RST;
            normal_bg_reg   <= NORMAL_BG_RST;
            screen_rows_reg <= SCREEN_ROWS_RST;
            screen_cols_reg <= SCREEN_COLS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_NORMAL_FG:   normal_fg_reg   <= cfg_wdata[3:0];
                CFG_NORMAL_BG:   normal_bg_reg   <= cfg_wdata[3:0];
                CFG_SCREEN_ROWS: screen_rows_reg <= cfg_wdata;
                CFG_SCREEN_COLS: screen_cols_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Terminal state, updated when a byte is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_GROUND;
            n1_reg     <= '0;
            n2_reg     <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            top_reg    <= '0;
            bottom_reg <= ROWS_RST;
            left_reg   <= '0;
            right_reg  <= COLS_RST;
            fg_reg     <= NORMAL_FG_RST;
            bg_reg     <= NORMAL_BG_RST;
            mode_reg   <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            n1_reg     <= n1_next;
            n2_reg     <= n2_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            fg_reg     <= fg_next;
            bg_reg     <= bg_next;
            mode_reg   <= mode_next;
        end
    end

    // Result queue control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(res_cnt);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_reg + (accept ? QCW'(res_cnt) : QCW'(0)) - QCW'(pop);
        end
    end

    // Result queue storage.
    always_ff @(posedge aclk) begin
        if (accept && res_cnt != 2'd0) begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (accept && res_cnt == 2'd2) begin
            queue_mem[wr_ptr_reg + QAW'(1)] <= res1;
        end
    end

    assign head = queue_mem[rd_ptr_reg];

    assign m_command       = head.command;
    assign m_cell_row      = head.cell_row;
    assign m_cell_col      = head.cell_col;
    assign m_glyph         = head.glyph;
    assign m_fore_index    = head.fore_index;
    assign m_back_index    = head.back_index;
    assign m_bold_on       = head.bold_on;
    assign m_region_top    = head.region_top;
    assign m_region_bottom = head.region_bottom;
    assign m_region_left   = head.region_left;
    assign m_region_right  = head.region_right;
    assign m_final_result  = head.final_result;

endmodule

### tb/text_terminal_escape_decoder_tb.sv
// Self-checking testbench for the text terminal escape decoder.
`timescale 1ns / 1ps

module text_terminal_escape_decoder_tb;
    import tted_pkg::*;

    localparam int ITEMS_PER_PHASE  = 310;
    localparam int RECV_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 3000;
    localparam int MAX_PRINTS       = 100;
    localparam logic [7:0] SEQ_FINALS [6] = '{CH_LC_B, CH_LC_F, CH_H, CH_LC_M, CH_R, CH_V};

    typedef struct {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [8:0] cfg_wdata = 9'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'd0;
    logic       s_end_of_write = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_command;
    logic [7:0] m_cell_row;
    logic [7:0] m_cell_col;
    logic [7:0] m_glyph;
    logic [3:0] m_fore_index;
    logic [3:0] m_back_index;
    logic       m_bold_on;
    logic [7:0] m_region_top;
    logic [8:0] m_region_bottom;
    logic [7:0] m_region_left;
    logic [8:0] m_region_right;
    logic       m_final_result;

    text_terminal_escape_decoder u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_write  (s_end_of_write),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command       (m_command),
        .m_cell_row      (m_cell_row),
        .m_cell_col      (m_cell_col),
        .m_glyph         (m_glyph),
        .m_fore_index    (m_fore_index),
        .m_back_index    (m_back_index),
        .m_bold_on       (m_bold_on),
        .m_region_top    (m_region_top),
        .m_region_bottom (m_region_bottom),
        .m_region_left   (m_region_left),
        .m_region_right  (m_region_right),
        .m_final_result  (m_final_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus and expected draw commands.
    tx_beat_t byte_q [$];
    result_t  draw_q [$];
    tx_beat_t next_beat;
    result_t  want_res;

    int send_idle_pct = 12;
    int rcv_idle_pct  = 59;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left    = 0;
    int stall_cycles = 0;
    int mismatch_count = 0;
    int draw_count = 0;

    // Decoder state as the block should hold it.
    phase_t     parse_st;
    logic [7:0] num_a, num_b;
    logic [7:0] row_at, col_at, reg_top, reg_left;
    logic [8:0] reg_bot, reg_right;
    logic [3:0] fg_cur, bg_cur;
    logic [1:0] mode_cur;
    logic [3:0] cfg_fg, cfg_bg;
    logic [8:0] cfg_rows, cfg_cols;
    result_t    step_res [2];
    int         step_cnt;

    function automatic int eff_size(logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > 9'd256) return 256;
        return int'(v);
    endfunction

    function automatic void reset_model();
        cfg_fg    = NORMAL_FG_RST;
        cfg_bg    = NORMAL_BG_RST;
        cfg_rows  = SCREEN_ROWS_RST;
        cfg_cols  = SCREEN_COLS_RST;
        parse_st  = PH_GROUND;
        num_a     = 8'd0;
        num_b     = 8'd0;
        row_at    = 8'd0;
        col_at    = 8'd0;
        reg_top   = 8'd0;
        reg_left  = 8'd0;
        reg_bot   = 9'(eff_size(cfg_rows));
        reg_right = 9'(eff_size(cfg_cols));
        fg_cur    = cfg_fg;
        bg_cur    = cfg_bg;
        mode_cur  = 2'd0;
    endfunction

    function automatic void add_cmd(cmd_t c, logic [7:0] row, logic [7:0] col, logic [7:0] g);
        result_t r;
        r.command       = c;
        r.cell_row      = row;
        r.cell_col      = col;
        r.glyph         = g;
        r.fore_index    = fg_cur;
        r.back_index    = bg_cur;
        r.bold_on       = mode_cur[MODE_BOLD_BIT];
        r.region_top    = reg_top;
        r.region_bottom = reg_bot;
        r.region_left   = reg_left;
        r.region_right  = reg_right;
        r.final_result  = 1'b0;
        if (step_cnt < 2) begin
            step_res[step_cnt] = r;
            step_cnt++;
        end
    endfunction

    function automatic logic [7:0] add_digit(logic [7:0] v, logic [7:0] b);
        int acc;
        acc = int'(v) * 10 + int'(b - CH_0);
        return (acc > 255) ? 8'd255 : 8'(acc);
    endfunction

    function automatic void ground_char(logic [7:0] b, logic eow);
        case (b)
            CH_BEL: ;
            CH_BS: begin
                if (col_at > reg_left) begin
                    col_at = col_at - 8'd1;
                end else if (row_at > reg_top) begin
                    row_at = row_at - 8'd1;
                    col_at = 8'(reg_right - 9'd1);
                end
            end
            CH_LF: begin
                col_at = reg_left;
                if (int'(row_at) + 1 >= int'(reg_bot)) begin
                    row_at = 8'(reg_bot - 9'd1);
                    add_cmd(CMD_SCROLL, row_at, col_at, 8'd0);
                end else begin
                    row_at = row_at + 8'd1;
                end
            end
            CH_CR: col_at = reg_left;
            CH_ESC: parse_st = eow ? PH_GROUND : PH_ESC;
            default: begin
                if (int'(col_at) < int'(reg_right)) begin
                    add_cmd(CMD_GLYPH, row_at, col_at, b);
                    if (int'(col_at) + 1 >= int'(reg_right)) begin
                        // Wrap to the left edge; on the region's last row the region scrolls.
                        col_at = reg_left;
                        if (int'(row_at) + 1 == int'(reg_bot)) begin
                            add_cmd(CMD_SCROLL, row_at, col_at, 8'd0);
                        end else if (row_at != 8'd255) begin
                            row_at = row_at + 8'd1;
                        end
                    end else begin
                        col_at = col_at + 8'd1;
                    end
                end
            end
        endcase
    endfunction

    function automatic void close_seq(logic [7:0] b);
        int lim;
        int hi;
        parse_st = PH_GROUND;
        case (b)
            CH_LC_B: if (int'(num_a) < COLOR_COUNT_DEF) bg_cur = num_a[3:0];
            CH_LC_F: if (int'(num_a) < COLOR_COUNT_DEF) fg_cur = num_a[3:0];
            CH_H: begin
                lim = eff_size(cfg_rows) - 1;
                row_at = (int'(num_a) > lim) ? 8'(lim) : num_a;
                lim = eff_size(cfg_cols) - 1;
                col_at = (int'(num_b) > lim) ? 8'(lim) : num_b;
            end
            CH_LC_M: begin
                if (mode_cur[MODE_REVERSE_BIT] != num_a[MODE_REVERSE_BIT]) begin
                    {fg_cur, bg_cur} = {bg_cur, fg_cur};
                end
                if (num_a == 8'd0) begin
                    bg_cur = cfg_bg;
                    fg_cur = cfg_fg;
                end
                mode_cur = num_a[1:0];
            end
            CH_R: begin
                lim = eff_size(cfg_rows);
                hi = int'(num_b) + 1;
                if (hi > lim) hi = lim;
                reg_bot = 9'(hi);
                reg_top = (int'(num_a) > hi - 1) ? 8'(hi - 1) : num_a;
            end
            CH_V: begin
                lim = eff_size(cfg_cols);
                hi = int'(num_b) + 1;
                if (hi > lim) hi = lim;
                reg_right = 9'(hi);
                reg_left = (int'(num_a) > hi - 1) ? 8'(hi - 1) : num_a;
            end
            default: add_cmd(CMD_ERROR, row_at, col_at, 8'd0);
        endcase
    endfunction

    // Advance the decoder state by one byte and queue the draw commands it causes.
    function automatic void decode_byte(logic [7:0] b, logic eow);
        logic is_digit;
        step_cnt = 0;
        is_digit = (b >= CH_0) && (b <= CH_9);
        case (parse_st)
            PH_ESC: begin
                if (b == CH_LBRACK) begin
                    parse_st = eow ? PH_GROUND : PH_CSI;
                end else begin
                    // A lone ESC is dropped and the byte is handled as in the ground state.
                    parse_st = PH_GROUND;
                    ground_char(b, eow);
                end
            end
            PH_CSI: begin
                parse_st = PH_GROUND;
                if (b == CH_J) begin
                    row_at = 8'd0;
                    col_at = 8'd0;
                    add_cmd(CMD_CLEAR, row_at, col_at, 8'd0);
                end else if (b == CH_K) begin
                    add_cmd(CMD_EOL, row_at, col_at, 8'd0);
                end else if (b == CH_L) begin
                    add_cmd(CMD_INSERT, row_at, col_at, 8'd0);
                end else if (is_digit && !eow) begin
                    num_a = b - CH_0;
                    num_b = 8'd0;
                    parse_st = PH_NUM1;
                end else begin
                    add_cmd(CMD_ERROR, row_at, col_at, 8'd0);
                end
            end
            PH_NUM1, PH_NUM2: begin
                if (is_digit || (b == CH_SEMI && parse_st == PH_NUM1)) begin
                    if (eow) begin
                        parse_st = PH_GROUND;
                        add_cmd(CMD_ERROR, row_at, col_at, 8'd0);
                    end else if (b == CH_SEMI) begin
                        parse_st = PH_NUM2;
                        num_b = 8'd0;
                    end else if (parse_st == PH_NUM1) begin
                        num_a = add_digit(num_a, b);
                    end else begin
                        num_b = add_digit(num_b, b);
                    end
                end else begin
                    close_seq(b);
                end
            end
            default: begin
                parse_st = PH_GROUND;
                ground_char(b, eow);
            end
        endcase
        if (step_cnt > 0) step_res[step_cnt - 1].final_result = 1'b1;
        for (int i = 0; i < step_cnt; i++) draw_q.push_back(step_res[i]);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic eow);
        tx_beat_t t;
        t.data = b;
        t.last = eow;
        byte_q.push_back(t);
    endfunction

    function automatic void push_csi(string body, logic eow_last);
        push_byte(CH_ESC, 1'b0);
        push_byte(CH_LBRACK, eow_last && body.len() == 0);
        for (int k = 0; k < body.len(); k++) begin
            push_byte(body[k], eow_last && k == body.len() - 1);
        end
    endfunction

    function automatic int pick_num();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(20);
        if (r < 90) return $urandom_range(255);
        return $urandom_range(99999, 256);
    endfunction

    // Append one random piece of terminal output; returns the number of bytes added.
    function automatic int add_random_piece();
        int sel;
        int len;
        int cnt;
        string body;
        logic [7:0] ctl;
        cnt = byte_q.size();
        sel = $urandom_range(99);
        if (sel < 30) begin
            len = $urandom_range(12, 1);
            repeat (len) push_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
        end else if (sel < 45) begin
            case ($urandom_range(3))
                0: ctl = CH_BEL;
                1: ctl = CH_BS;
                2: ctl = CH_LF;
                default: ctl = CH_CR;
            endcase
            len = $urandom_range(6, 1);
            repeat (len) push_byte(ctl, $urandom_range(9) == 0);
        end else if (sel < 53) begin
            case ($urandom_range(2))
                0: body = "J";
                1: body = "K";
                default: body = "L";
            endcase
            push_csi(body, $urandom_range(4) == 0);
        end else if (sel < 85) begin
            body = $sformatf("%0d", pick_num());
            if ($urandom_range(3) != 0) begin
                body = {body, ";"};
                // Sometimes the second number is left out after the separator.
                if ($urandom_range(5) != 0) body = {body, $sformatf("%0d", pick_num())};
            end
            body = $sformatf("%s%c", body, SEQ_FINALS[$urandom_range(5)]);
            push_csi(body, $urandom_range(4) == 0);
        end else begin
            case ($urandom_range(7))
                0: push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                1: begin
                    push_byte(CH_ESC, 1'b0);
                    push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                2: push_byte(CH_ESC, 1'b1);
                3: push_csi("", 1'b1);
                4: begin
                    push_csi("", 1'b0);
                    push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                5: push_csi($sformatf("%0d", pick_num()), 1'b1);
                6: push_csi($sformatf("%0d;", pick_num()), 1'b1);
                default: begin
                    push_csi($sformatf("%0d;%0d", pick_num(), pick_num()), 1'b0);
                    push_byte(8'($urandom_range(255)), 1'b0);
                end
            endcase
        end
        return byte_q.size() - cnt;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, int got_v, int want_v);
        if (got_v != want_v) begin
            report_mismatch($sformatf("command %0d field %s: got %0d, want %0d",
                                      draw_count, name, got_v, want_v));
        end
    endtask

    // Wait until every byte is taken and every draw command has come back.
    task automatic drain();
        do @(negedge aclk); while (byte_q.size() != 0 || s_valid || draw_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(logic [3:0] fg, logic [3:0] bg, logic [8:0] rows,
                              logic [8:0] cols);
        logic [8:0] vals [4];
        vals = '{{5'd0, fg}, {5'd0, bg}, rows, cols};
        for (int k = 0; k < 4; k++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_idx_t'(k);
            cfg_wdata <= vals[k];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_fg   = fg;
        cfg_bg   = bg;
        cfg_rows = rows;
        cfg_cols = cols;
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        int n;
        @(negedge aclk);
        send_idle_pct = send_pct;
        rcv_idle_pct  = recv_pct;
        // Stall the receiver for a long stretch while the bytes are offered.
        hold_req = ~hold_req;
        n = 0;
        while (n < ITEMS_PER_PHASE) n += add_random_piece();
        drain();
    endtask

    // Driver: offers one byte per beat and predicts the results of each accepted one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) decode_byte(s_data_byte, s_end_of_write);
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = byte_q.pop_front();
                    s_valid        <= 1'b1;
                    s_data_byte    <= next_beat.data;
                    s_end_of_write <= next_beat.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each draw command beat against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (draw_q.size() == 0) begin
                    report_mismatch($sformatf("command %0d arrived with nothing expected",
                                              draw_count));
                end else begin
                    want_res = draw_q.pop_front();
                    check_field("command", m_command, want_res.command);
                    check_field("cell_row", m_cell_row, want_res.cell_row);
                    check_field("cell_col", m_cell_col, want_res.cell_col);
                    check_field("glyph", m_glyph, want_res.glyph);
                    check_field("fore_index", m_fore_index, want_res.fore_index);
                    check_field("back_index", m_back_index, want_res.back_index);
                    check_field("bold_on", m_bold_on, want_res.bold_on);
                    check_field("region_top", m_region_top, want_res.region_top);
                    check_field("region_bottom", m_region_bottom, want_res.region_bottom);
                    check_field("region_left", m_region_left, want_res.region_left);
                    check_field("region_right", m_region_right, want_res.region_right);
                    check_field("final_result", m_final_result, want_res.final_result);
                end
                draw_count++;
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= RECV_HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed bytes: byte extremes, each control, each unnumbered CSI command, a cursor move
        // and a doubled separator that must end in an error.
        @(negedge aclk);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(CH_BEL, 1'b0);
        push_byte(CH_BS, 1'b0);
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_csi("J", 1'b0);
        push_csi("K", 1'b0);
        push_csi("L", 1'b0);
        push_csi("7;3H", 1'b0);
        push_csi("9;;", 1'b0);
        run_phase(12, 59);

        write_regs(4'd15, 4'd0, 9'd256, 9'd256);
        run_phase(59, 12);

        write_regs(4'd7, 4'd9, 9'd1, 9'd1);
        run_phase(0, 0);

        // Out-of-range sizes: zero reads as one, anything above the maximum as the maximum.
        write_regs(4'd3, 4'd12, 9'd0, 9'd511);
        run_phase(0, 0);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### text_terminal_escape_decoder.f
sv/tted_pkg.sv
sv/text_terminal_escape_decoder.sv
tb/text_terminal_escape_decoder_tb.sv
